// ===== src/sldc_pkg.sv =====
// Package for the street light dimming controller.
// Holds the request and result types, command and register codes, and constants.
// No dependencies.
package sldc_pkg;

	localparam int NUM_LAMPS    = 5;
	localparam int MOTION_W     = 4;
	localparam int LEVEL_W      = 7;
	localparam int DUSK_W       = 8;
	localparam int BLINK_W      = 6;
	localparam int CFG_W        = 8;
	localparam int CFG_IDX_W    = 2;

	localparam logic [LEVEL_W-1:0] PWM_TOP      = LEVEL_W'(100);
	localparam logic [BLINK_W-1:0] BLINK_PERIOD = BLINK_W'(50);

	// motion bits that actually sit between two lamps
	localparam int MOTION_USED = (NUM_LAMPS - 1 < MOTION_W) ? NUM_LAMPS - 1 : MOTION_W;
	localparam logic [MOTION_W-1:0] MOTION_MASK = MOTION_W'((1 << MOTION_USED) - 1);

	// configuration register reset values
	localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST  = LEVEL_W'(20);
	localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RST = LEVEL_W'(100);
	localparam logic [DUSK_W-1:0]  DUSK_TICKS_RST = DUSK_W'(100);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_LEVEL  = 2'd0,
		REG_HIGH_LEVEL = 2'd1,
		REG_DUSK_TICKS = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_SENSE = 2'd0,
		CMD_FAST  = 2'd1,
		CMD_SLOW  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_DAY   = 2'd0,
		MODE_DUSK  = 2'd1,
		MODE_NIGHT = 2'd2,
		MODE_RSVD  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]          command;
		logic                dark;
		logic [MOTION_W-1:0] motion;
	} sense_req_t;

	typedef struct packed {
		logic [NUM_LAMPS-1:0] lamp_on;
		logic [1:0]           light_mode;
		logic                 status_led;
	} lamp_rsp_t;

	// strobes from the controller to the lamp level bank
	typedef struct packed {
		logic                load_low;
		logic                motion_upd;
		logic                decay;
		logic [MOTION_W-1:0] motion;
	} lamp_ctl_t;

endpackage

// ===== src/sldc_lamp_bank.sv =====
// Per-lamp duty level and decay flag registers with PWM compare.
// Depends on sldc_pkg.
module sldc_lamp_bank (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sldc_pkg::lamp_ctl_t                    ctl,
	input  logic [sldc_pkg::LEVEL_W-1:0]           low_level,
	input  logic [sldc_pkg::LEVEL_W-1:0]           high_level,
	input  logic [sldc_pkg::LEVEL_W-1:0]           pwm_next,
	output logic [sldc_pkg::NUM_LAMPS-1:0]         pwm_bits
);
	import sldc_pkg::*;

	logic [LEVEL_W-1:0]   level_q   [NUM_LAMPS];
	logic [LEVEL_W-1:0]   level_d   [NUM_LAMPS];
	logic [NUM_LAMPS-1:0] pending_q;
	logic [NUM_LAMPS-1:0] pending_d;
	logic [MOTION_W-1:0]  hit_m;
	logic [MOTION_W-1:0]  miss_m;
	logic [NUM_LAMPS:0]   hit_e;
	logic [NUM_LAMPS:0]   miss_e;

	// motion bit k covers lamps k and k+1: shift by one so lamp j sees bits j-1 and j
	assign hit_m  = ctl.motion & MOTION_MASK;
	assign miss_m = ~ctl.motion & MOTION_MASK;
	assign hit_e  = (NUM_LAMPS+1)'({hit_m, 1'b0});
	assign miss_e = (NUM_LAMPS+1)'({miss_m, 1'b0});

	// next levels and decay flags
	always_comb begin
		for (int j = 0; j < NUM_LAMPS; j++) begin
			level_d[j]   = level_q[j];
			pending_d[j] = pending_q[j];
			if (ctl.motion_upd) begin
				if (ctl.load_low) begin
					level_d[j] = low_level;
				end
				if (hit_e[j] || hit_e[j+1]) begin
					level_d[j] = high_level;
				end
				if (miss_e[j] || miss_e[j+1]) begin
					pending_d[j] = 1'b1;
				end
			end else if (ctl.decay && pending_q[j]) begin
				if (level_q[j] > low_level) begin
					level_d[j] = level_q[j] - LEVEL_W'(1);
				end else begin
					pending_d[j] = 1'b0;
				end
			end
		end
	end

	// PWM compare against the stepped counter
	always_comb begin
		for (int j = 0; j < NUM_LAMPS; j++) begin
			pwm_bits[j] = (pwm_next < level_q[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_LAMPS; j++) begin
				level_q[j] <= '0;
			end
			pending_q <= '0;
		end else begin
			for (int j = 0; j < NUM_LAMPS; j++) begin
				level_q[j] <= level_d[j];
			end
			pending_q <= pending_d;
		end
	end

endmodule

// ===== src/street_light_dimming_controller_core.sv =====
// Street light dimming controller: day, dusk and night lamp control with PWM dimming.
// A request is held in the input register, and its result is held in the result register.
// Throughput: one request per cycle while out_stall is low, set by the single input register stage.
// The result register and input stage let a new request in while a result waits.
// Reset (arst_n low) clears all mode, level, counter and pipeline state at once;
// configuration registers return to 20, 100 and 100.
module street_light_dimming_controller_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  sldc_pkg::sense_req_t                  in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output sldc_pkg::lamp_rsp_t                   out_data,
	input  logic                                  cfg_we,
	input  logic [sldc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sldc_pkg::CFG_W-1:0]            cfg_wdata
);
	import sldc_pkg::*;

	// configuration
	logic [LEVEL_W-1:0] low_level_q;
	logic [LEVEL_W-1:0] high_level_q;
	logic [DUSK_W-1:0]  dusk_ticks_q;

	// pipeline
	logic       valid_s1;
	sense_req_t req_s1;
	logic       out_valid_q;
	lamp_rsp_t  out_q;
	logic       advance;

	// controller state
	mode_t                mode_q,        mode_d;
	logic                 dusk_started_q, dusk_started_d;
	logic                 day_q,          day_d;
	logic                 night_q,        night_d;
	logic [DUSK_W-1:0]    dusk_count_q,   dusk_count_d;
	logic [LEVEL_W-1:0]   pwm_count_q,    pwm_count_d;
	logic                 running_q,      running_d;
	logic [BLINK_W-1:0]   blink_q,        blink_d;
	logic                 led_q,          led_d;
	logic [NUM_LAMPS-1:0] lamp_bits_q,    lamp_bits_d;

	lamp_ctl_t            lamp_ctl;
	logic [NUM_LAMPS-1:0] pwm_bits;
	logic [BLINK_W-1:0]   blink_inc;
	lamp_rsp_t            rsp_d;

	// handshake
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_level_q  <= LOW_LEVEL_RST;
			high_level_q <= HIGH_LEVEL_RST;
			dusk_ticks_q <= DUSK_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_LEVEL:  low_level_q  <= cfg_wdata[LEVEL_W-1:0];
				REG_HIGH_LEVEL: high_level_q <= cfg_wdata[LEVEL_W-1:0];
				REG_DUSK_TICKS: dusk_ticks_q <= cfg_wdata[DUSK_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_data;
		end
	end

	assign blink_inc = blink_q + BLINK_W'(1);

	// next state for the request in the input register
	always_comb begin
		mode_d         = mode_q;
		dusk_started_d = dusk_started_q;
		day_d          = day_q;
		night_d        = night_q;
		dusk_count_d   = dusk_count_q;
		pwm_count_d    = pwm_count_q;
		running_d      = running_q;
		blink_d        = blink_q;
		led_d          = led_q;
		lamp_bits_d    = lamp_bits_q;
		lamp_ctl       = '{load_low: 1'b0, motion_upd: 1'b0, decay: 1'b0,
		                   motion: req_s1.motion};
		case (req_s1.command)
			CMD_SENSE: begin
				if (!req_s1.dark) begin
					if (!day_q) begin
						running_d      = 1'b0;
						lamp_bits_d    = '0;
						day_d          = 1'b1;
						mode_d         = MODE_DUSK;
						dusk_started_d = 1'b0;
					end
				end else if (mode_q == MODE_DUSK) begin
					if (!dusk_started_q) begin
						dusk_started_d = 1'b1;
						day_d          = 1'b0;
						night_d        = 1'b0;
						lamp_bits_d    = '1;
						dusk_count_d   = '0;
					end
				end else begin
					lamp_ctl.motion_upd = advance;
					if (!night_q) begin
						day_d             = 1'b0;
						night_d           = 1'b1;
						running_d         = 1'b1;
						lamp_ctl.load_low = 1'b1;
					end
				end
			end
			CMD_FAST: begin
				if (running_q) begin
					if (pwm_count_q >= PWM_TOP) begin
						pwm_count_d = '0;
					end else begin
						pwm_count_d = pwm_count_q + LEVEL_W'(1);
					end
					lamp_bits_d = pwm_bits;
				end
			end
			CMD_SLOW: begin
				lamp_ctl.decay = advance;
				blink_d = (blink_inc >= BLINK_PERIOD) ? '0 : blink_inc;
				if (blink_d == BLINK_W'(0) || blink_d == BLINK_W'(2)) begin
					led_d = 1'b1;
				end else if (blink_d == BLINK_W'(1) || blink_d == BLINK_W'(3)) begin
					led_d = 1'b0;
				end
				if (dusk_started_q) begin
					dusk_count_d = dusk_count_q + DUSK_W'(1);
					if (dusk_count_q >= dusk_ticks_q) begin
						mode_d       = MODE_NIGHT;
						dusk_count_d = '0;
					end
				end
			end
			default: ;
		endcase
	end

	// result from the updated state
	always_comb begin
		rsp_d.lamp_on    = lamp_bits_d;
		rsp_d.light_mode = day_d ? MODE_DAY : mode_d;
		rsp_d.status_led = led_d;
	end

	sldc_lamp_bank u_lamp_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (lamp_ctl),
		.low_level  (low_level_q),
		.high_level (high_level_q),
		.pwm_next   (pwm_count_d),
		.pwm_bits   (pwm_bits)
	);

	// state commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_DUSK;
			dusk_started_q <= 1'b0;
			day_q          <= 1'b0;
			night_q        <= 1'b0;
			dusk_count_q   <= '0;
			pwm_count_q    <= '0;
			running_q      <= 1'b0;
			blink_q        <= '0;
			led_q          <= 1'b0;
			lamp_bits_q    <= '0;
		end else if (advance) begin
			mode_q         <= mode_d;
			dusk_started_q <= dusk_started_d;
			day_q          <= day_d;
			night_q        <= night_d;
			dusk_count_q   <= dusk_count_d;
			pwm_count_q    <= pwm_count_d;
			running_q      <= running_d;
			blink_q        <= blink_d;
			led_q          <= led_d;
			lamp_bits_q    <= lamp_bits_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= rsp_d;
		end
	end

`ifndef SYNTHESIS
	// PWM counter never passes its top value
	a_pwm_range: assert property (@(posedge clk) disable iff (!arst_n)
		pwm_count_q <= PWM_TOP)
		else $error("pwm counter above top");

	// blink counter stays inside its period
	a_blink_range: assert property (@(posedge clk) disable iff (!arst_n)
		blink_q < BLINK_PERIOD)
		else $error("blink counter out of period");

	// PWM never runs in daylight
	a_day_no_pwm: assert property (@(posedge clk) disable iff (!arst_n)
		!(day_q && running_q))
		else $error("pwm running in day mode");

	// a request held behind a stalled result is kept
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |=> valid_s1)
		else $error("request lost while result stalled");
`endif

endmodule
